@@ sv/rrv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrv_pkg: shared types and constants for the range repulsion velocity block
// Payload structs, push classes, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package rrv_pkg;

    // Field and register widths
    localparam int RANGE_W     = 16;
    localparam int CFG_W       = 12;
    localparam int SPEED_W     = 10;
    localparam int IDX_W       = 3;
    localparam int VX_W        = 13;
    localparam int VY_W        = 12;

    // Datapath widths
    localparam int NUM_SENSORS = 5;
    localparam int DIST_W      = 12;
    localparam int NUM_W       = SPEED_W + DIST_W;
    localparam int Q_W         = SPEED_W;
    localparam int PUSH_W      = 12;

    // Divider: quotient bits resolved per stage and number of stages
    localparam int DIV_STEP    = 2;
    localparam int DIV_STAGES  = Q_W / DIV_STEP;

    // Accept edge to result edge: classify, multiply, divider, push, sum
    localparam int PIPE_LAT    = DIV_STAGES + 4;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_INNER = 3'd0;
    localparam logic [IDX_W-1:0] CFG_OUTER = 3'd1;
    localparam logic [IDX_W-1:0] CFG_MIN   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_MAX   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PULL  = 3'd4;

    // Push class of one reading
    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_FULL = 2'd1;
    localparam logic [1:0] PUSH_LIN  = 2'd2;
    localparam logic [1:0] PUSH_PULL = 2'd3;

    // Sensor slots
    localparam int SEN_FRONT  = 0;
    localparam int SEN_RIGHT  = 1;
    localparam int SEN_BACK   = 2;
    localparam int SEN_LEFT   = 3;
    localparam int SEN_STEREO = 4;

    // Sensors whose push points towards negative x or y
    localparam logic [NUM_SENSORS-1:0] SUBTRACT_MASK = 5'b10011;

    typedef struct packed {
        logic signed [RANGE_W-1:0] front_range;
        logic signed [RANGE_W-1:0] right_range;
        logic signed [RANGE_W-1:0] back_range;
        logic signed [RANGE_W-1:0] left_range;
        logic signed [RANGE_W-1:0] stereo_range_mm;
    } range_in_t;

    typedef struct packed {
        logic signed [VX_W-1:0] vel_x;
        logic signed [VY_W-1:0] vel_y;
    } vel_out_t;

    typedef struct packed {
        logic [1:0]        code;
        logic [DIST_W-1:0] span;
    } sense_t;

endpackage
`default_nettype wire

@@ sv/rrv_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrv_div: pipelined restoring divider
// Resolves DIV_STEP quotient bits per stage; the push class rides alongside.
// ----------------------------------------------------------------------------
module rrv_div
    import rrv_pkg::*;
(
    input  logic              clk,
    input  logic [NUM_W-1:0]  num,
    input  logic [DIST_W-1:0] den,
    input  logic [1:0]        code_in,
    output logic [Q_W-1:0]    quo,
    output logic [1:0]        code_out
);

    logic [NUM_W-1:0] rem_in   [DIV_STAGES];
    logic [Q_W-1:0]   quo_in   [DIV_STAGES];
    logic [1:0]       code_s   [DIV_STAGES];
    logic [NUM_W-1:0] rem_next [DIV_STAGES];
    logic [Q_W-1:0]   quo_next [DIV_STAGES];
    logic [Q_W-1:0]   quo_reg  [DIV_STAGES];
    logic [1:0]       code_reg [DIV_STAGES];
    logic [NUM_W-1:0] rem_reg  [DIV_STAGES-1];

    // Feed the first stage from the ports
    assign rem_in[0] = num;
    assign quo_in[0] = '0;
    assign code_s[0] = code_in;

    generate
        for (genvar s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            // Chain each stage onto the previous one
            if (s > 0)
            begin : g_link
                assign rem_in[s] = rem_reg[s-1];
                assign quo_in[s] = quo_reg[s-1];
                assign code_s[s] = code_reg[s-1];
            end

            // Trial-subtract the shifted divisor for this stage's bits
            always_comb
            begin
                logic [NUM_W-1:0] rem;
                logic [Q_W-1:0]   q;
                logic [NUM_W-1:0] trial;
                rem = rem_in[s];
                q   = quo_in[s];
                for (int j = 0; j < DIV_STEP; j++)
                begin
                    trial = NUM_W'(den) << (Q_W - 1 - s * DIV_STEP - j);
                    if (rem >= trial)
                    begin
                        rem = rem - trial;
                        q[Q_W - 1 - s * DIV_STEP - j] = 1'b1;
                    end
                end
                rem_next[s] = rem;
                quo_next[s] = q;
            end

            // Hold the partial quotient and class
            always_ff @(posedge clk)
            begin
                quo_reg[s]  <= quo_next[s];
                code_reg[s] <= code_s[s];
            end

            // Hold the partial remainder for the next stage
            if (s < DIV_STAGES - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    rem_reg[s] <= rem_next[s];
                end
            end
        end
    endgenerate

    assign quo      = quo_reg[DIV_STAGES-1];
    assign code_out = code_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ sv/range_repulsion_velocity.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted start transfer passes through classify, multiply, five divider
// stages, push select, sum and output register, then strobes its result on done.
// Throughput: one reading set per cycle; busy stays low and the receiver cannot stall.
// Reset: clears the valid pipeline and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// range_repulsion_velocity: range readings to repulsive x/y velocity pushes
// Five sensors are classified, scaled and divided in parallel lanes and summed.
// ----------------------------------------------------------------------------
module range_repulsion_velocity
    import rrv_pkg::*;
#(
    parameter int SENSOR_LIMIT_MM = 2000
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  range_in_t        ranges,
    output logic             done,
    output vel_out_t         vel,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam logic signed [RANGE_W:0] LIMIT = (RANGE_W+1)'(SENSOR_LIMIT_MM);
    localparam logic signed [RANGE_W:0] ONE   = (RANGE_W+1)'(1);

    // Configuration registers
    logic [CFG_W-1:0]   inner_border_mm_reg;
    logic [CFG_W-1:0]   outer_border_mm_reg;
    logic [SPEED_W-1:0] min_speed_reg;
    logic [SPEED_W-1:0] max_speed_reg;
    logic [CFG_W-1:0]   forward_pull_range_mm_reg;

    // Pipeline valid bits
    logic                  v1_reg;
    logic                  v2_reg;
    logic [DIV_STAGES-1:0] vdiv_reg;
    logic                  v3_reg;
    logic                  done_reg;

    // Pipeline payload
    logic signed [RANGE_W:0]   r_ext       [NUM_SENSORS];
    sense_t                    sense_next  [NUM_SENSORS];
    sense_t                    s1_sense_reg[NUM_SENSORS];
    logic [NUM_W-1:0]          num_next    [NUM_SENSORS];
    logic [NUM_W-1:0]          s2_num_reg  [NUM_SENSORS];
    logic [1:0]                s2_code_reg [NUM_SENSORS];
    logic [Q_W-1:0]            div_quo     [NUM_SENSORS];
    logic [1:0]                div_code    [NUM_SENSORS];
    logic signed [PUSH_W-1:0]  push_next   [NUM_SENSORS];
    logic signed [PUSH_W-1:0]  s3_push_reg [NUM_SENSORS];
    vel_out_t                  vel_next;
    vel_out_t                  vel_reg;

    // Config-derived terms
    logic signed [RANGE_W:0] inner_ext;
    logic signed [RANGE_W:0] outer_ext;
    logic signed [RANGE_W:0] pull_ext;
    logic [SPEED_W:0]        speed_diff;
    logic                    diff_neg;
    logic [SPEED_W-1:0]      diff_mag;
    logic [DIST_W-1:0]       band_den;

    // Class a reading against the inner and outer borders
    function automatic sense_t band_class(
        input logic signed [RANGE_W:0] r,
        input logic signed [RANGE_W:0] inner,
        input logic signed [RANGE_W:0] outer
    );
        sense_t s;
        s.code = PUSH_NONE;
        s.span = DIST_W'(outer - r);
        if (r < inner)
        begin
            s.code = PUSH_FULL;
        end
        else if (r < outer)
        begin
            s.code = PUSH_LIN;
        end
        return s;
    endfunction

    assign busy = 1'b0;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_border_mm_reg       <= CFG_W'(1000);
            outer_border_mm_reg       <= CFG_W'(1400);
            min_speed_reg             <= SPEED_W'(100);
            max_speed_reg             <= SPEED_W'(300);
            forward_pull_range_mm_reg <= CFG_W'(2000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INNER: inner_border_mm_reg       <= cfg_data;
                CFG_OUTER: outer_border_mm_reg       <= cfg_data;
                CFG_MIN:   min_speed_reg             <= cfg_data[SPEED_W-1:0];
                CFG_MAX:   max_speed_reg             <= cfg_data[SPEED_W-1:0];
                CFG_PULL:  forward_pull_range_mm_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Derive borders, speed span and band width
    assign inner_ext  = (RANGE_W+1)'(inner_border_mm_reg);
    assign outer_ext  = (RANGE_W+1)'(outer_border_mm_reg);
    assign pull_ext   = (RANGE_W+1)'(forward_pull_range_mm_reg);
    assign speed_diff = {1'b0, max_speed_reg} - {1'b0, min_speed_reg};
    assign diff_neg   = speed_diff[SPEED_W];
    assign diff_mag   = diff_neg ? SPEED_W'(-speed_diff) : speed_diff[SPEED_W-1:0];
    assign band_den   = DIST_W'(outer_border_mm_reg - inner_border_mm_reg);

    // Sign-extend the readings
    assign r_ext[SEN_FRONT]  = {ranges.front_range[RANGE_W-1], ranges.front_range};
    assign r_ext[SEN_RIGHT]  = {ranges.right_range[RANGE_W-1], ranges.right_range};
    assign r_ext[SEN_BACK]   = {ranges.back_range[RANGE_W-1], ranges.back_range};
    assign r_ext[SEN_LEFT]   = {ranges.left_range[RANGE_W-1], ranges.left_range};
    assign r_ext[SEN_STEREO] = {ranges.stereo_range_mm[RANGE_W-1], ranges.stereo_range_mm};

    // Stage 1: classify each reading
    always_comb
    begin
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            sense_next[i] = band_class(r_ext[i], inner_ext, outer_ext);
            if (i == SEN_STEREO)
            begin
                // Stereo has an upper check only
                if (r_ext[i] > LIMIT)
                begin
                    sense_next[i].code = PUSH_NONE;
                end
            end
            else if (r_ext[i] < ONE || r_ext[i] > LIMIT)
            begin
                sense_next[i].code = PUSH_NONE;
            end
            else if (i == SEN_FRONT && r_ext[i] >= outer_ext && r_ext[i] >= inner_ext)
            begin
                // Front beyond both borders may pull forward
                sense_next[i].code = (r_ext[i] > pull_ext) ? PUSH_PULL : PUSH_NONE;
            end
        end
    end

    // Stage 2: scale the band distance by the speed span
    always_comb
    begin
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            num_next[i] = NUM_W'(diff_mag) * NUM_W'(s1_sense_reg[i].span);
        end
    end

    // Stages 1 and 2 payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            s1_sense_reg[i] <= sense_next[i];
            s2_num_reg[i]   <= num_next[i];
            s2_code_reg[i]  <= s1_sense_reg[i].code;
        end
    end

    // Divide each lane by the band width
    generate
        for (genvar g = 0; g < NUM_SENSORS; g++)
        begin : g_lane
            rrv_div u_div (
                .clk      (clk),
                .num      (s2_num_reg[g]),
                .den      (band_den),
                .code_in  (s2_code_reg[g]),
                .quo      (div_quo[g]),
                .code_out (div_code[g])
            );
        end
    endgenerate

    // Stage 3: pick each lane's signed contribution
    always_comb
    begin
        logic signed [PUSH_W-1:0] mag;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            case (div_code[i])
                PUSH_FULL: mag = PUSH_W'(max_speed_reg);
                PUSH_LIN:  mag = diff_neg ? -PUSH_W'(div_quo[i]) : PUSH_W'(div_quo[i]);
                default:   mag = '0;
            endcase
            if (div_code[i] == PUSH_PULL)
            begin
                push_next[i] = PUSH_W'(max_speed_reg);
            end
            else
            begin
                push_next[i] = SUBTRACT_MASK[i] ? -mag : mag;
            end
        end
    end

    // Stage 4: sum the lanes into x and y
    always_comb
    begin
        vel_next.vel_x = VX_W'(s3_push_reg[SEN_FRONT]) + VX_W'(s3_push_reg[SEN_BACK])
                       + VX_W'(s3_push_reg[SEN_STEREO]);
        vel_next.vel_y = VY_W'(s3_push_reg[SEN_RIGHT]) + VY_W'(s3_push_reg[SEN_LEFT]);
    end

    // Stages 3 and 4 payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            s3_push_reg[i] <= push_next[i];
        end
        vel_reg <= vel_next;
    end

    // Advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vdiv_reg <= '0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            vdiv_reg <= {vdiv_reg[DIV_STAGES-2:0], v2_reg};
            v3_reg   <= vdiv_reg[DIV_STAGES-1];
            done_reg <= v3_reg;
        end
    end

    assign done = done_reg;
    assign vel  = vel_reg;

    // Every accepted transfer yields exactly one result
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("accepted transfer produced no result");

    // No result without a transfer at the matching cycle
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result strobe without a matching transfer");

    // Sums stay within three and two lanes of full speed
    a_vel_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (vel.vel_x >= -13'sd3069 && vel.vel_x <= 13'sd3069
               && vel.vel_y >= -12'sd2046 && vel.vel_y <= 12'sd2046))
        else $error("velocity sum out of range");

endmodule
`default_nettype wire
